>>> rtl/core/hsv2rgb_pkg.sv
// shared types and constants of the hsv to rgb converter
// no dependencies; imported by every module of the block
`default_nettype none

package hsv2rgb_pkg;

  // input ranges
  localparam int unsigned HueMax     = 3600;
  localparam int unsigned PctMax     = 100;
  localparam int unsigned SectorSpan = 600;

  // level factor full scale (x of the v level)
  localparam int unsigned FullScale  = 60000;

  // level = floor((17*v*x + 200000) / 400000), with 400000 = 128 * 3125
  localparam int unsigned LevelMul   = 17;
  localparam int unsigned LevelBias  = 200000;
  localparam int unsigned DivShift   = 7;
  // exact reciprocal of 3125 for 20-bit dividends: ceil(2^32 / 3125)
  localparam int unsigned RecipMul   = 1374390;
  localparam int unsigned RecipShift = 32;

  localparam int unsigned HueW    = 12;
  localparam int unsigned PctW    = 7;
  localparam int unsigned RemW    = 10;
  localparam int unsigned FactorW = 16;
  localparam int unsigned VMulW   = 11;
  localparam int unsigned NumW    = 27;
  localparam int unsigned QuotW   = NumW - DivShift;
  localparam int unsigned RecipW  = 21;
  localparam int unsigned ChanW   = 8;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  typedef logic [FactorW-1:0] factor_t;
  typedef logic [ChanW-1:0]   chan_t;

  // load enables of the two level stages
  typedef struct packed {
    logic prod;
    logic quot;
  } lvl_en_t;

endpackage

`default_nettype wire

>>> rtl/core/hsv2rgb_sector.sv
// first stage: clamps the inputs and splits the hue into sector and remainder
// depends on hsv2rgb_pkg
`default_nettype none

module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [HueW-1:0] hue_i,
  input  wire logic [PctW-1:0] sat_i,
  input  wire logic [PctW-1:0] val_i,
  output sector_e              sector_o,
  output logic [RemW-1:0]      rem_o,
  output logic [PctW-1:0]      sat_o,
  output logic [PctW-1:0]      val_o
);

  sector_e         sector_d, sector_q;
  logic [HueW-1:0] rem_full;
  logic [PctW-1:0] sat_d, sat_q, val_d, val_q;

  always_comb begin
    sat_d = (sat_i > PctW'(PctMax)) ? PctW'(PctMax) : sat_i;
    val_d = (val_i > PctW'(PctMax)) ? PctW'(PctMax) : val_i;
    // full circle and above fold onto the red side
    if (hue_i >= HueW'(HueMax)) begin
      sector_d = SEC_RED_YEL;
      rem_full = '0;
    end else if (hue_i >= HueW'(5 * SectorSpan)) begin
      sector_d = SEC_MAG_RED;
      rem_full = hue_i - HueW'(5 * SectorSpan);
    end else if (hue_i >= HueW'(4 * SectorSpan)) begin
      sector_d = SEC_BLU_MAG;
      rem_full = hue_i - HueW'(4 * SectorSpan);
    end else if (hue_i >= HueW'(3 * SectorSpan)) begin
      sector_d = SEC_CYN_BLU;
      rem_full = hue_i - HueW'(3 * SectorSpan);
    end else if (hue_i >= HueW'(2 * SectorSpan)) begin
      sector_d = SEC_GRN_CYN;
      rem_full = hue_i - HueW'(2 * SectorSpan);
    end else if (hue_i >= HueW'(SectorSpan)) begin
      sector_d = SEC_YEL_GRN;
      rem_full = hue_i - HueW'(SectorSpan);
    end else begin
      sector_d = SEC_RED_YEL;
      rem_full = hue_i;
    end
  end

  logic [RemW-1:0] rem_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sector_q <= sector_d;
      rem_q    <= rem_full[RemW-1:0];
      sat_q    <= sat_d;
      val_q    <= val_d;
    end
  end

  assign sector_o = sector_q;
  assign rem_o    = rem_q;
  assign sat_o    = sat_q;
  assign val_o    = val_q;

endmodule

`default_nettype wire

>>> rtl/core/hsv2rgb_factor.sv
// second stage: level factors of p, q and t and the scaled value
// depends on hsv2rgb_pkg
`default_nettype none

module hsv2rgb_factor
  import hsv2rgb_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [RemW-1:0] rem_i,
  input  wire logic [PctW-1:0] sat_i,
  input  wire logic [PctW-1:0] val_i,
  output factor_t              x_p_o,
  output factor_t              x_q_o,
  output factor_t              x_t_o,
  output logic [VMulW-1:0]     v_mul_o
);

  localparam int unsigned ProdW = PctW + RemW;

  logic [ProdW-1:0] y_p, y_q, y_t;
  logic [RemW-1:0]  rem_inv;
  factor_t          x_p_q, x_q_q, x_t_q;
  logic [VMulW-1:0] v_mul_q;

  always_comb begin
    rem_inv = RemW'(SectorSpan) - rem_i;
    y_p     = ProdW'(sat_i) * ProdW'(SectorSpan);
    y_q     = ProdW'(sat_i) * ProdW'(rem_i);
    y_t     = ProdW'(sat_i) * ProdW'(rem_inv);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_p_q   <= FactorW'(FullScale) - y_p[FactorW-1:0];
      x_q_q   <= FactorW'(FullScale) - y_q[FactorW-1:0];
      x_t_q   <= FactorW'(FullScale) - y_t[FactorW-1:0];
      v_mul_q <= VMulW'(val_i) * VMulW'(LevelMul);
    end
  end

  assign x_p_o   = x_p_q;
  assign x_q_o   = x_q_q;
  assign x_t_o   = x_t_q;
  assign v_mul_o = v_mul_q;

endmodule

`default_nettype wire

>>> rtl/core/hsv2rgb_level.sv
// third and fourth stages of one level: product with bias, then rounded quotient
// depends on hsv2rgb_pkg
`default_nettype none

module hsv2rgb_level
  import hsv2rgb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire lvl_en_t          en_i,
  input  wire logic [VMulW-1:0] v_mul_i,
  input  wire factor_t          x_i,
  output chan_t                 level_o
);

  localparam int unsigned RProdW = QuotW + RecipW;

  logic [NumW-1:0]   num_q;
  logic [QuotW-1:0]  dividend;
  logic [RProdW-1:0] rprod;
  chan_t             level_q;

  // num < 2^27, so num >> 7 fits the 20 bits the reciprocal is exact for
  assign dividend = num_q[NumW-1:DivShift];
  assign rprod    = RProdW'(dividend) * RProdW'(RecipMul);

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      num_q <= NumW'(v_mul_i) * NumW'(x_i) + NumW'(LevelBias);
    end
    if (en_i.quot) begin
      level_q <= rprod[RecipShift +: ChanW];
    end
  end

  assign level_o = level_q;

endmodule

`default_nettype wire

>>> rtl/core/hsv_to_rgb_converter.sv
// top level of the hsv to rgb converter: stall control and channel select
// depends on hsv2rgb_pkg, hsv2rgb_sector, hsv2rgb_factor, hsv2rgb_level
`default_nettype none

// hsv to rgb converter, five register stages
//
// input channel: hue_i (tenths of a degree), saturation_i and brightness_i
// (percent) with in_valid_i / in_ready_o; out-of-range values clamp to 3600
// and 100. output channel: red_o, green_o, blue_o with out_valid_o /
// out_ready_i. an item moves on each edge where valid and ready are high.
//
// the five-stage pipeline (clamp and sector split, level factors, level
// product, reciprocal quotient, channel select) takes one item per cycle
// while the receiver does not stall.
//
// reset clears every stage valid bit; data registers are not reset. when the
// receiver stalls, the output stage holds its item and the hold walks back
// stage by stage; empty stages keep loading, so bubbles are squeezed out and
// in_ready_o drops only once all five stages are full.

module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [HueW-1:0] hue_i,
  input  wire logic [PctW-1:0] saturation_i,
  input  wire logic [PctW-1:0] brightness_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic [ChanW-1:0]     red_o,
  output logic [ChanW-1:0]     green_o,
  output logic [ChanW-1:0]     blue_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i
);

  localparam int unsigned NumStages = 5;

  // stage valid bits and load enables, index 0 is the first stage
  logic [NumStages-1:0] vld_q, vld_d, en;

  always_comb begin
    en[NumStages-1] = ~vld_q[NumStages-1] | out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStages-1];

  // stage 1: clamp and sector split
  sector_e         sec_s1;
  logic [RemW-1:0] rem_s1;
  logic [PctW-1:0] sat_s1, val_s1;

  hsv2rgb_sector u_sector (
    .clk_i    (clk_i),
    .en_i     (en[0]),
    .hue_i    (hue_i),
    .sat_i    (saturation_i),
    .val_i    (brightness_i),
    .sector_o (sec_s1),
    .rem_o    (rem_s1),
    .sat_o    (sat_s1),
    .val_o    (val_s1)
  );

  // stage 2: factors of p, q, t and 17*v
  factor_t          x_p_s2, x_q_s2, x_t_s2;
  logic [VMulW-1:0] v_mul_s2;

  hsv2rgb_factor u_factor (
    .clk_i   (clk_i),
    .en_i    (en[1]),
    .rem_i   (rem_s1),
    .sat_i   (sat_s1),
    .val_i   (val_s1),
    .x_p_o   (x_p_s2),
    .x_q_o   (x_q_s2),
    .x_t_o   (x_t_s2),
    .v_mul_o (v_mul_s2)
  );

  // stages 3 and 4: the four levels, v uses the full-scale factor
  lvl_en_t lvl_en;
  chan_t   lv_s4, lp_s4, lq_s4, lt_s4;

  assign lvl_en.prod = en[2];
  assign lvl_en.quot = en[3];

  hsv2rgb_level u_level_v (
    .clk_i   (clk_i),
    .en_i    (lvl_en),
    .v_mul_i (v_mul_s2),
    .x_i     (FactorW'(FullScale)),
    .level_o (lv_s4)
  );

  hsv2rgb_level u_level_p (
    .clk_i   (clk_i),
    .en_i    (lvl_en),
    .v_mul_i (v_mul_s2),
    .x_i     (x_p_s2),
    .level_o (lp_s4)
  );

  hsv2rgb_level u_level_q (
    .clk_i   (clk_i),
    .en_i    (lvl_en),
    .v_mul_i (v_mul_s2),
    .x_i     (x_q_s2),
    .level_o (lq_s4)
  );

  hsv2rgb_level u_level_t (
    .clk_i   (clk_i),
    .en_i    (lvl_en),
    .v_mul_i (v_mul_s2),
    .x_i     (x_t_s2),
    .level_o (lt_s4)
  );

  // sector rides along with the levels
  sector_e sec_s2_q, sec_s3_q, sec_s4_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sec_s2_q <= sec_s1;
    end
    if (en[2]) begin
      sec_s3_q <= sec_s2_q;
    end
    if (en[3]) begin
      sec_s4_q <= sec_s3_q;
    end
  end

  // stage 5: pick v, p, q or t for each channel
  chan_t red_d, green_d, blue_d, red_q, green_q, blue_q;

  always_comb begin
    case (sec_s4_q)
      SEC_RED_YEL: begin
        red_d = lv_s4; green_d = lt_s4; blue_d = lp_s4;
      end
      SEC_YEL_GRN: begin
        red_d = lq_s4; green_d = lv_s4; blue_d = lp_s4;
      end
      SEC_GRN_CYN: begin
        red_d = lp_s4; green_d = lv_s4; blue_d = lt_s4;
      end
      SEC_CYN_BLU: begin
        red_d = lp_s4; green_d = lq_s4; blue_d = lv_s4;
      end
      SEC_BLU_MAG: begin
        red_d = lt_s4; green_d = lp_s4; blue_d = lv_s4;
      end
      default: begin
        red_d = lv_s4; green_d = lp_s4; blue_d = lq_s4;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  // back-pressure only once every stage holds an item
  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q))
    else $error("input stalled with an empty stage");

  // an accepted item lands in the first stage
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted item missing from first stage");

  // a held stage four keeps its item
  a_hold_s4 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[3] && !en[3]) |=> vld_q[3])
    else $error("stalled item dropped from stage four");

  // an empty output stage never blocks the input
  a_empty_out_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output stage empty");

endmodule

`default_nettype wire

>>> verif/tb_hsv_to_rgb_converter.sv
// self-checking testbench of the hsv to rgb converter: directed table, then random colors
// depends on hsv2rgb_pkg and hsv_to_rgb_converter, which also needs its stage modules

module tb_hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
;

  // scaling of one channel level: round(255 * v * x / 6000000), halves up
  localparam longint unsigned ChanFull = 255;
  localparam longint unsigned LevelDen = 100 * FullScale;

  localparam int NumDirected    = 24;
  localparam int RandomItems    = 1650;
  localparam int CalmItems      = 120;  // gap-free items around the long receiver hold
  localparam int LongHoldCycles = 40;
  localparam int DrainCycles    = 20;   // leave room for strays
  localparam int TimeoutUnits   = 5_000_000;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // one color still owed by the block, with its input kept for messages
  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] bri;
    rgb_t            rgb;
  } rgb_entry_t;

  // directed row; typed rgb is used only where fixed is set
  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] bri;
    logic            fixed;
    rgb_t            rgb;
  } stim_row_t;

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic [HueW-1:0] hue_i        = '0;
  logic [PctW-1:0] saturation_i = '0;
  logic [PctW-1:0] brightness_i = '0;
  logic            in_valid_i   = 1'b0;
  logic            in_ready_o;
  logic [ChanW-1:0] red_o;
  logic [ChanW-1:0] green_o;
  logic [ChanW-1:0] blue_o;
  logic            out_valid_o;
  logic            out_ready_i  = 1'b0;

  rgb_entry_t  pending_rgb_q[$];
  int unsigned err_count = 0;
  int unsigned hold_reqs = 0;  // bumped by the sender, served by the receiver process

  // hue, sat, bri, fixed, expected rgb
  stim_row_t directed_rows [NumDirected] = '{
    '{12'd0,    7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},    // black right after reset
    '{12'd0,    7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0}},    // pure red
    '{12'd600,  7'd100, 7'd100, 1'b1, '{8'd255, 8'd255, 8'd0}},    // yellow
    '{12'd1200, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd0}},    // green
    '{12'd1800, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd255}},  // cyan
    '{12'd2400, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd255}},  // blue
    '{12'd3000, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd255}},  // magenta
    '{12'd3600, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0}},    // full circle wraps to red
    '{12'd4095, 7'd127, 7'd127, 1'b1, '{8'd255, 8'd0,   8'd0}},    // all fields clamp
    '{12'd3601, 7'd101, 7'd101, 1'b1, '{8'd255, 8'd0,   8'd0}},    // just above range
    '{12'd1234, 7'd0,   7'd50,  1'b1, '{8'd128, 8'd128, 8'd128}},  // grey, half rounds up
    '{12'd2000, 7'd0,   7'd127, 1'b1, '{8'd255, 8'd255, 8'd255}},  // white, value clamps
    '{12'd4095, 7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{12'd599,  7'd100, 7'd100, 1'b0, '0},  // last step before a sector edge
    '{12'd300,  7'd50,  7'd50,  1'b0, '0},
    '{12'd3599, 7'd73,  7'd99,  1'b0, '0},
    '{12'd1,    7'd1,   7'd1,   1'b0, '0},
    '{12'd2047, 7'd64,  7'd64,  1'b0, '0},
    '{12'd2048, 7'd63,  7'd63,  1'b0, '0},
    '{12'd3000, 7'd127, 7'd1,   1'b0, '0},
    '{12'd900,  7'd100, 7'd100, 1'b0, '0},
    '{12'd2700, 7'd37,  7'd100, 1'b0, '0},
    '{12'd1500, 7'd100, 7'd3,   1'b0, '0},
    '{12'd4000, 7'd20,  7'd127, 1'b0, '0}
  };

  hsv_to_rgb_converter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one channel level for value pct and factor x (0..60000)
  function automatic chan_t scale_level(input longint unsigned pct, input longint unsigned x);
    return chan_t'((ChanFull * pct * x + LevelDen / 2) / LevelDen);
  endfunction

  // expected color of one hsv item
  function automatic rgb_t hsv_to_rgb(input logic [HueW-1:0] hue, input logic [PctW-1:0] sat,
                                      input logic [PctW-1:0] bri);
    longint unsigned h, s, v, rem;
    logic [2:0]      sec_raw;
    sector_e         sec;
    chan_t           lv, lp, lq, lt;
    rgb_t            res;
    h = (hue > HueMax) ? HueMax : hue;
    s = (sat > PctMax) ? PctMax : sat;
    v = (bri > PctMax) ? PctMax : bri;
    rem = h % SectorSpan;
    sec_raw = 3'(h / SectorSpan);
    // 3600 lands in a seventh sector; it is red again
    sec = (sec_raw > 3'(SEC_MAG_RED)) ? SEC_RED_YEL : sector_e'(sec_raw);
    lv = scale_level(v, FullScale);
    lp = scale_level(v, FullScale - SectorSpan * s);
    lq = scale_level(v, FullScale - s * rem);
    lt = scale_level(v, FullScale - s * (SectorSpan - rem));
    case (sec)
      SEC_RED_YEL: res = '{lv, lt, lp};
      SEC_YEL_GRN: res = '{lq, lv, lp};
      SEC_GRN_CYN: res = '{lp, lv, lt};
      SEC_CYN_BLU: res = '{lp, lq, lv};
      SEC_BLU_MAG: res = '{lt, lp, lv};
      default:     res = '{lv, lp, lq};
    endcase
    return res;
  endfunction

  task automatic flag_error(input string msg);
    $display("%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_chan(input string name, input chan_t got, input rgb_entry_t ent,
                            input chan_t want);
    if (got !== want) begin
      flag_error($sformatf("%s got %0d want %0d for hue %0d sat %0d val %0d",
                           name, got, want, ent.hue, ent.sat, ent.bri));
    end
  endtask

  // offer one item and hold it until the block takes it
  task automatic send_item(input logic [HueW-1:0] hue, input logic [PctW-1:0] sat,
                           input logic [PctW-1:0] bri, input rgb_t want);
    hue_i        <= hue;
    saturation_i <= sat;
    brightness_i <= bri;
    in_valid_i   <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // taken at this edge; its color cannot come out before the next one
    pending_rgb_q.push_back('{hue, sat, bri, want});
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // stop offering and wait until the block has handed back every color
  task automatic drain_results();
    in_valid_i <= 1'b0;
    wait (pending_rgb_q.size() == 0);
    @(posedge clk_i);
  endtask

  // percent field: mostly in range, some at the ends, some in the clamped zone
  function automatic logic [PctW-1:0] rand_pct();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 78) return PctW'($urandom_range(0, PctMax));
    if (roll < 88) return (roll[0]) ? PctW'(PctMax) : '0;
    return PctW'($urandom_range(0, 127));
  endfunction

  function automatic logic [HueW-1:0] rand_hue();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return HueW'($urandom_range(0, HueMax));
    // around a sector boundary, full circle included
    if (roll < 90) return HueW'(SectorSpan * $urandom_range(1, 6) - 1 + $urandom_range(0, 2));
    return HueW'($urandom_range(0, 4095));
  endfunction

  // result checker: every taken color against the oldest one owed
  always @(posedge clk_i) begin
    rgb_entry_t ent;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rgb_q.size() == 0) begin
        flag_error($sformatf("unexpected color %0d/%0d/%0d", red_o, green_o, blue_o));
      end else begin
        ent = pending_rgb_q.pop_front();
        check_chan("red", red_o, ent, ent.rgb.red);
        check_chan("green", green_o, ent, ent.rgb.green);
        check_chan("blue", blue_o, ent, ent.rgb.blue);
      end
    end
  end

  // receiver: runs of ready, short and long stalls, and the long hold on request
  initial begin
    int unsigned holds_done;
    int          roll;
    int          span;
    logic        ready_lvl;
    holds_done = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (holds_done != hold_reqs) begin
        // long hold so the pipeline fills and in_ready_o drops
        ready_lvl = 1'b0;
        span = LongHoldCycles;
        holds_done++;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          ready_lvl = 1'b1;
          span = $urandom_range(4, 60);
        end else if (roll < 90) begin
          ready_lvl = 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          ready_lvl = 1'b0;
          span = $urandom_range(8, 30);
        end
      end
      out_ready_i <= ready_lvl;
      repeat (span) @(posedge clk_i);
    end
  end

  // run limit
  initial begin
    #(TimeoutUnits);
    $display("[hsv_to_rgb_converter] ERROR");
    $finish;
  end

  // stimulus: directed table, pause, then random colors
  initial begin
    stim_row_t row;
    rgb_t      want;
    logic [HueW-1:0] h;
    logic [PctW-1:0] s;
    logic [PctW-1:0] b;
    bit        calm;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part; rows without a typed color go through the predictor
    for (int i = 0; i < NumDirected; i++) begin
      row = directed_rows[i];
      want = row.fixed ? row.rgb : hsv_to_rgb(row.hue, row.sat, row.bri);
      send_item(row.hue, row.sat, row.bri, want);
      idle_sender(pick_gap());
    end
    drain_results();

    // random part; the first stretch is gap-free while the receiver holds off
    hold_reqs++;
    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) drain_results();
      h = rand_hue();
      s = rand_pct();
      b = rand_pct();
      send_item(h, s, b, hsv_to_rgb(h, s, b));
      // every third block of 64 items runs back to back
      calm = (n < CalmItems) || ((n / 64) % 3 == 0);
      if (!calm) idle_sender(pick_gap());
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_rgb_q.size() != 0) begin
      flag_error($sformatf("%0d colors never came out", pending_rgb_q.size()));
    end
    if (err_count == 0) begin
      $display("[hsv_to_rgb_converter] OK");
    end else begin
      $display("[hsv_to_rgb_converter] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv2rgb_sector.sv
rtl/core/hsv2rgb_factor.sv
rtl/core/hsv2rgb_level.sv
rtl/core/hsv_to_rgb_converter.sv
verif/tb_hsv_to_rgb_converter.sv
